>>> rtl/core/pinned_node_cache_lookup_defines.svh
// ----------------------------------------------------------------------------
// pinned node cache assertion macros
// shared concurrent assertion forms for the cache checker
// ----------------------------------------------------------------------------
`ifndef PINNED_NODE_CACHE_LOOKUP_DEFINES_SVH
`define PINNED_NODE_CACHE_LOOKUP_DEFINES_SVH

// same-cycle implication, off during reset
`define PNC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PNC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pnc_pkg.sv
// ----------------------------------------------------------------------------
// pinned node cache package
// field widths, operation codes and sequencer states
// ----------------------------------------------------------------------------
package pnc_pkg;

    localparam int KEY_W  = 64;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 16;

    localparam logic OP_LOOKUP  = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REL
    } pnc_state_t;

endpackage

>>> rtl/core/pinned_node_cache_lookup.sv
// ----------------------------------------------------------------------------
// pinned node cache lookup
// fully associative key table with reference-count pinning
// ----------------------------------------------------------------------------
// usage
//   command channel: a word (op, lookup_key, release_slot) is taken at a
//   rising edge with start high and busy low; busy stays high until the
//   result is produced
//   result channel: done is high for one cycle with hit, slot, filled,
//   evicted, evicted_key, full_res, ref_count and bad_release; the receiver
//   must take it in that cycle, there is no back pressure
// timing
//   lookup: the table ram is read one entry per cycle from slot 0; a hit in
//   slot k ends the scan at that entry, a miss reads every entry first
//   release: one ram read, then the result
//   the single ram read port sets the scan rate, and the next command is
//   taken in the cycle done is high
// reset
//   rst_n clears the valid marks and the sequencer; key and count storage is
//   left as is and only read behind a valid mark
// ----------------------------------------------------------------------------
module pinned_node_cache_lookup
    import pnc_pkg::*;
#(
    parameter int ENTRIES  = 64,
    parameter int REF_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              op,
    input  logic [KEY_W-1:0]  lookup_key,
    input  logic [SLOT_W-1:0] release_slot,
    output logic              done,
    output logic              hit,
    output logic [SLOT_W-1:0] slot,
    output logic              filled,
    output logic              evicted,
    output logic [KEY_W-1:0]  evicted_key,
    output logic              full_res,
    output logic [CNT_W-1:0]  ref_count,
    output logic              bad_release
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ENT_W = KEY_W + REF_BITS;
    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [REF_BITS-1:0] REF_MAX  = '1;
    localparam logic [REF_BITS-1:0] REF_ONE  = REF_BITS'(1);

    // sequencer state
    pnc_state_t state_reg, state_next;

    // command capture
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [IDX_W-1:0]  rel_idx_reg, rel_idx_next;
    logic [SLOT_W-1:0] rel_slot_reg, rel_slot_next;
    logic              rel_oor_reg, rel_oor_next;

    // scan issue side and read-data side
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic              issue_done_reg, issue_done_next;
    logic              dv_reg, dv_next;
    logic [IDX_W-1:0]  didx_reg, didx_next;
    logic              dvalid_reg, dvalid_next;

    // first empty and first unreferenced entry seen so far
    logic              empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]  empty_idx_reg, empty_idx_next;
    logic              idle_found_reg, idle_found_next;
    logic [IDX_W-1:0]  idle_idx_reg, idle_idx_next;
    logic [KEY_W-1:0]  idle_key_reg, idle_key_next;

    logic [ENTRIES-1:0] valid_reg;
    logic               valid_set;
    logic [IDX_W-1:0]   valid_idx;

    // table ram
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;
    logic [KEY_W-1:0]  rd_key;
    logic [REF_BITS-1:0] rd_refs;

    // result being formed
    logic                res_fire;
    logic                res_hit;
    logic                res_filled;
    logic                res_evicted;
    logic [KEY_W-1:0]    res_ekey;
    logic                res_full;
    logic                res_bad;
    logic                res_use_rel;
    logic [IDX_W-1:0]    res_idx;
    logic [REF_BITS-1:0] res_cnt;
    logic [SLOT_W-1:0]   res_slot;
    logic [IDX_W+SLOT_W-1:0]   res_idx_wide;
    logic [REF_BITS+CNT_W-1:0] res_cnt_wide;

    // release slot mapping
    logic [IDX_W+SLOT_W-1:0] rel_wide;
    logic [31:0]             rel_ext;

    // scan helpers
    logic                match_here;
    logic                empty_here;
    logic                idle_here;
    logic                emp_any;
    logic [IDX_W-1:0]    emp_idx;
    logic                idl_any;
    logic [IDX_W-1:0]    idl_idx;
    logic [KEY_W-1:0]    idl_key;
    logic [REF_BITS-1:0] hit_cnt;

    // output registers
    logic              done_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              filled_reg;
    logic              evicted_reg;
    logic [KEY_W-1:0]  evicted_key_reg;
    logic              full_res_reg;
    logic [CNT_W-1:0]  ref_count_reg;
    logic              bad_release_reg;

    pnc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[ENT_W-1:REF_BITS];
    assign rd_refs = ram_rdata[REF_BITS-1:0];

    assign rel_wide = {{IDX_W{1'b0}}, release_slot};
    assign rel_ext  = 32'(release_slot);

    // entry under compare
    assign match_here = dvalid_reg && (rd_key == key_reg);
    assign empty_here = !dvalid_reg;
    assign idle_here  = dvalid_reg && (rd_refs == '0);
    assign hit_cnt    = (rd_refs == REF_MAX) ? rd_refs : rd_refs + REF_ONE;

    // victim choice including the entry under compare
    assign emp_any = empty_found_reg || empty_here;
    assign emp_idx = empty_found_reg ? empty_idx_reg : didx_reg;
    assign idl_any = idle_found_reg || idle_here;
    assign idl_idx = idle_found_reg ? idle_idx_reg : didx_reg;
    assign idl_key = idle_found_reg ? idle_key_reg : rd_key;

    always_comb
    begin
        state_next       = state_reg;
        key_next         = key_reg;
        rel_idx_next     = rel_idx_reg;
        rel_slot_next    = rel_slot_reg;
        rel_oor_next     = rel_oor_reg;
        scan_next        = scan_reg;
        issue_done_next  = issue_done_reg;
        dv_next          = 1'b0;
        didx_next        = didx_reg;
        dvalid_next      = dvalid_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        idle_found_next  = idle_found_reg;
        idle_idx_next    = idle_idx_reg;
        idle_key_next    = idle_key_reg;

        ram_we    = 1'b0;
        ram_waddr = didx_reg;
        ram_wdata = {key_reg, REF_ONE};
        ram_re    = 1'b0;
        ram_raddr = scan_reg;
        valid_set = 1'b0;
        valid_idx = didx_reg;

        res_fire    = 1'b0;
        res_hit     = 1'b0;
        res_filled  = 1'b0;
        res_evicted = 1'b0;
        res_ekey    = '0;
        res_full    = 1'b0;
        res_bad     = 1'b0;
        res_use_rel = 1'b0;
        res_idx     = '0;
        res_cnt     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_RELEASE)
                    begin
                        rel_idx_next  = rel_wide[IDX_W-1:0];
                        rel_slot_next = release_slot;
                        rel_oor_next  = (rel_ext >= 32'(ENTRIES));
                        ram_re        = (rel_ext < 32'(ENTRIES));
                        ram_raddr     = rel_wide[IDX_W-1:0];
                        state_next    = ST_REL;
                    end
                    else
                    begin
                        key_next         = lookup_key;
                        scan_next        = '0;
                        issue_done_next  = 1'b0;
                        empty_found_next = 1'b0;
                        idle_found_next  = 1'b0;
                        state_next       = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue side: one read per cycle
                if (!issue_done_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = scan_reg;
                    dv_next     = 1'b1;
                    didx_next   = scan_reg;
                    dvalid_next = valid_reg[scan_reg];
                    if (scan_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + IDX_W'(1);
                    end
                end

                // compare side
                if (dv_reg)
                begin
                    if (match_here)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = didx_reg;
                        ram_wdata  = {key_reg, hit_cnt};
                        res_fire   = 1'b1;
                        res_hit    = 1'b1;
                        res_idx    = didx_reg;
                        res_cnt    = hit_cnt;
                        dv_next    = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (empty_here && !empty_found_reg)
                        begin
                            empty_found_next = 1'b1;
                            empty_idx_next   = didx_reg;
                        end
                        if (idle_here && !idle_found_reg)
                        begin
                            idle_found_next = 1'b1;
                            idle_idx_next   = didx_reg;
                            idle_key_next   = rd_key;
                        end
                        if (didx_reg == LAST_IDX)
                        begin
                            res_fire   = 1'b1;
                            dv_next    = 1'b0;
                            state_next = ST_IDLE;
                            if (emp_any)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = emp_idx;
                                valid_set  = 1'b1;
                                valid_idx  = emp_idx;
                                res_filled = 1'b1;
                                res_idx    = emp_idx;
                                res_cnt    = REF_ONE;
                            end
                            else if (idl_any)
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = idl_idx;
                                res_filled  = 1'b1;
                                res_evicted = 1'b1;
                                res_ekey    = idl_key;
                                res_idx     = idl_idx;
                                res_cnt     = REF_ONE;
                            end
                            else
                            begin
                                res_full = 1'b1;
                            end
                        end
                    end
                end
            end

            ST_REL:
            begin
                res_fire    = 1'b1;
                res_use_rel = 1'b1;
                state_next  = ST_IDLE;
                if (rel_oor_reg || !valid_reg[rel_idx_reg] || (rd_refs == '0))
                begin
                    res_bad = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rel_idx_reg;
                    ram_wdata = {rd_key, rd_refs - REF_ONE};
                    res_cnt   = rd_refs - REF_ONE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // narrow slot and count to the result field widths
    assign res_idx_wide = {{SLOT_W{1'b0}}, res_idx};
    assign res_slot     = res_use_rel ? rel_slot_reg : res_idx_wide[SLOT_W-1:0];
    assign res_cnt_wide = {{CNT_W{1'b0}}, res_cnt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            issue_done_reg  <= 1'b0;
            dv_reg          <= 1'b0;
            empty_found_reg <= 1'b0;
            idle_found_reg  <= 1'b0;
            valid_reg       <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            issue_done_reg  <= issue_done_next;
            dv_reg          <= dv_next;
            empty_found_reg <= empty_found_next;
            idle_found_reg  <= idle_found_next;
            done_reg        <= res_fire;
            if (valid_set)
            begin
                valid_reg[valid_idx] <= 1'b1;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        rel_idx_reg   <= rel_idx_next;
        rel_slot_reg  <= rel_slot_next;
        rel_oor_reg   <= rel_oor_next;
        scan_reg      <= scan_next;
        didx_reg      <= didx_next;
        dvalid_reg    <= dvalid_next;
        empty_idx_reg <= empty_idx_next;
        idle_idx_reg  <= idle_idx_next;
        idle_key_reg  <= idle_key_next;
        if (res_fire)
        begin
            hit_reg         <= res_hit;
            slot_reg        <= res_slot;
            filled_reg      <= res_filled;
            evicted_reg     <= res_evicted;
            evicted_key_reg <= res_ekey;
            full_res_reg    <= res_full;
            ref_count_reg   <= res_cnt_wide[CNT_W-1:0];
            bad_release_reg <= res_bad;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign slot        = slot_reg;
    assign filled      = filled_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;
    assign full_res    = full_res_reg;
    assign ref_count   = ref_count_reg;
    assign bad_release = bad_release_reg;

endmodule

>>> rtl/core/pnc_ram.sv
// ----------------------------------------------------------------------------
// pnc generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/pnc_checker.sv
// ----------------------------------------------------------------------------
// pnc port checker
// watches the command and result ports of the cache over time
// ----------------------------------------------------------------------------
`include "pinned_node_cache_lookup_defines.svh"

module pnc_checker
    import pnc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              hit,
    input logic              filled,
    input logic              full_res,
    input logic [CNT_W-1:0]  ref_count,
    input logic              bad_release
);

    // an accepted word always occupies the block
    `PNC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept without busy")

    // a result ends the busy period
    `PNC_ASSERT_SAME(a_done_ends_busy, clk, rst_n, done, !busy && $past(busy), "stray result word")

    // result kinds are exclusive
    `PNC_ASSERT_SAME(a_kind_excl, clk, rst_n, done, $onehot0({hit, filled, full_res, bad_release}), "mixed result kinds")

    // a fill always starts at one reference
    `PNC_ASSERT_SAME(a_fill_count, clk, rst_n, done && filled, ref_count == CNT_W'(1), "fill count not one")

    // failed operations report a zero count
    `PNC_ASSERT_SAME(a_fail_count, clk, rst_n, done && (bad_release || full_res), ref_count == '0, "nonzero count on failure")

endmodule

bind pinned_node_cache_lookup pnc_checker u_pnc_checker (.*);

>>> bench/pinned_node_cache_lookup_chk.sv
// ----------------------------------------------------------------------------
// pinned node cache checker
// follows the command and result channels, keeps its own copy of the key
// table, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pinned_node_cache_lookup_chk
    import pnc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              op,
    input  logic [KEY_W-1:0]  lookup_key,
    input  logic [SLOT_W-1:0] release_slot,
    input  logic              done,
    input  logic              hit,
    input  logic [SLOT_W-1:0] slot,
    input  logic              filled,
    input  logic              evicted,
    input  logic [KEY_W-1:0]  evicted_key,
    input  logic              full_res,
    input  logic [CNT_W-1:0]  ref_count,
    input  logic              bad_release,
    output int                errors,
    output int                pending
);

    localparam int TABLE_DEPTH = 64;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              filled;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
        logic              full_res;
        logic [CNT_W-1:0]  ref_count;
        logic              bad_release;
    } cache_reply_t;

    // shadow table
    logic             tbl_valid [TABLE_DEPTH];
    logic [KEY_W-1:0] tbl_key   [TABLE_DEPTH];
    logic [CNT_W-1:0] tbl_refs  [TABLE_DEPTH];

    cache_reply_t reply_q [$];
    cache_reply_t want;

    int words_checked;
    int n_hits;
    int n_ceiling_hits;
    int n_fills;
    int n_evictions;
    int n_full;
    int n_releases;
    int n_bad_releases;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        begin
            $display("mismatch in %s on result %0d: got 0x%0h, expected 0x%0h",
                     what, words_checked, got, exp_val);
            errors++;
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] exp_val);
        begin
            if (got !== exp_val)
                report_mismatch(what, got, exp_val);
        end
    endtask

    // applies one command word to the shadow table and returns its result
    function automatic cache_reply_t apply_cache_word(input logic cmd,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [SLOT_W-1:0] rel);
        cache_reply_t r;
        int empty_at;
        int idle_at;
        int victim;
        r = '0;
        empty_at = -1;
        idle_at = -1;
        if (cmd == OP_RELEASE)
        begin
            n_releases++;
            r.slot = rel;
            if (!tbl_valid[rel] || tbl_refs[rel] == '0)
            begin
                r.bad_release = 1'b1;
                n_bad_releases++;
            end
            else
            begin
                tbl_refs[rel] = tbl_refs[rel] - 1'b1;
                r.ref_count = tbl_refs[rel];
            end
            return r;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (tbl_valid[i])
            begin
                if (tbl_key[i] == key)
                begin
                    if (tbl_refs[i] != COUNT_MAX)
                        tbl_refs[i] = tbl_refs[i] + 1'b1;
                    else
                        n_ceiling_hits++;
                    n_hits++;
                    r.hit = 1'b1;
                    r.slot = SLOT_W'(i);
                    r.ref_count = tbl_refs[i];
                    return r;
                end
                if (idle_at < 0 && tbl_refs[i] == '0)
                    idle_at = i;
            end
            else if (empty_at < 0)
            begin
                empty_at = i;
            end
        end
        victim = (empty_at >= 0) ? empty_at : idle_at;
        if (victim < 0)
        begin
            n_full++;
            r.full_res = 1'b1;
            return r;
        end
        n_fills++;
        if (tbl_valid[victim])
        begin
            n_evictions++;
            r.evicted = 1'b1;
            r.evicted_key = tbl_key[victim];
        end
        tbl_valid[victim] = 1'b1;
        tbl_key[victim] = key;
        tbl_refs[victim] = CNT_W'(1);
        r.filled = 1'b1;
        r.slot = SLOT_W'(victim);
        r.ref_count = CNT_W'(1);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                tbl_valid[i] = 1'b0;
            reply_q.delete();
            errors = 0;
            words_checked = 0;
            n_hits = 0;
            n_ceiling_hits = 0;
            n_fills = 0;
            n_evictions = 0;
            n_full = 0;
            n_releases = 0;
            n_bad_releases = 0;
            pending <= 0;
        end
        else
        begin
            // result of an earlier word first, a word may be taken in the same cycle
            if (done)
            begin
                if (reply_q.size() == 0)
                begin
                    report_mismatch("result with no word pending", 64'd0, 64'd0);
                end
                else
                begin
                    want = reply_q.pop_front();
                    check_field("hit", 64'(hit), 64'(want.hit));
                    check_field("slot", 64'(slot), 64'(want.slot));
                    check_field("filled", 64'(filled), 64'(want.filled));
                    check_field("evicted", 64'(evicted), 64'(want.evicted));
                    check_field("evicted_key", evicted_key, want.evicted_key);
                    check_field("full_res", 64'(full_res), 64'(want.full_res));
                    check_field("ref_count", 64'(ref_count), 64'(want.ref_count));
                    check_field("bad_release", 64'(bad_release), 64'(want.bad_release));
                end
                words_checked++;
            end
            if (start && !busy)
                reply_q.push_back(apply_cache_word(op, lookup_key, release_slot));
            pending <= reply_q.size();
        end
    end

endmodule

>>> bench/pinned_node_cache_lookup_tb.sv
// ----------------------------------------------------------------------------
// pinned node cache lookup testbench
// drives lookup and release words in bursts with random gaps, runs a stretch
// of back-to-back hits, then alternates fill-heavy and release-heavy random
// phases; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pinned_node_cache_lookup_tb;

    import pnc_pkg::*;

    localparam int TABLE_DEPTH = 64;
    // slowest run: about 800 words, each at most a full table scan plus a
    // random gap, which stays below this limit
    localparam int CYCLE_LIMIT = 2_000_000;
    // back-to-back hits on one key with no idling in between
    localparam int STEADY_RUN = 40;
    localparam int POOL_SIZE = 48;
    localparam int PHASES = 8;
    localparam int PHASE_WORDS = 92;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              op = OP_LOOKUP;
    logic [KEY_W-1:0]  lookup_key = '0;
    logic [SLOT_W-1:0] release_slot = '0;

    logic              busy;
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              filled;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic              full_res;
    logic [CNT_W-1:0]  ref_count;
    logic              bad_release;

    int chk_errors;
    int chk_pending;

    int cycles = 0;
    int burst_left = 0;
    bit steady = 1'b0;

    // keys that come back again and again, so lookups hit as well as miss
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pinned_node_cache_lookup uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .lookup_key  (lookup_key),
        .release_slot(release_slot),
        .done        (done),
        .hit         (hit),
        .slot        (slot),
        .filled      (filled),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .full_res    (full_res),
        .ref_count   (ref_count),
        .bad_release (bad_release)
    );

    pinned_node_cache_lookup_chk chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .lookup_key  (lookup_key),
        .release_slot(release_slot),
        .done        (done),
        .hit         (hit),
        .slot        (slot),
        .filled      (filled),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .full_res    (full_res),
        .ref_count   (ref_count),
        .bad_release (bad_release),
        .errors      (chk_errors),
        .pending     (chk_pending)
    );

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, chk_pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one word on the command channel; returns at the edge that takes it
    task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key,
                             input logic [SLOT_W-1:0] rel);
        int gap;
        begin
            // end of a burst: drop start for a while, mostly short, now and
            // then long enough to land anywhere inside a full table scan
            if (!steady && burst_left == 0)
            begin
                start <= 1'b0;
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 80)
                                                  : $urandom_range(1, 3);
                repeat (gap) @(posedge clk);
                // some long bursts give stretches with no idling at all
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 7);
            end
            else if (burst_left > 0)
            begin
                burst_left--;
            end
            start <= 1'b1;
            op <= cmd;
            lookup_key <= key;
            release_slot <= rel;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    // hold off until every word sent so far has produced its result
    task automatic drain_results;
        begin
            start <= 1'b0;
            burst_left = 0;
            do
                @(posedge clk);
            while (chk_pending != 0);
        end
    endtask

    function automatic logic [KEY_W-1:0] any_key();
        return {$urandom, $urandom};
    endfunction

    // one random word; fill phases mostly look up, drain phases mostly release
    task automatic send_random_word(input bit fill_phase);
        int pick;
        logic [KEY_W-1:0] key;
        begin
            pick = $urandom_range(0, 99);
            if (pick < (fill_phase ? 15 : 70))
            begin
                // unused key field carries noise
                send_word(OP_RELEASE, any_key(), SLOT_W'($urandom_range(0, TABLE_DEPTH-1)));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    key = key_pool[$urandom_range(0, POOL_SIZE-1)];
                else if (pick < 80)
                    key = any_key();
                else
                    key = key_pool[$urandom_range(0, 7)];
                send_word(OP_LOOKUP, key, SLOT_W'($urandom));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = any_key();
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: releases on an empty table are rejected
        send_word(OP_RELEASE, '1, 6'd0);
        send_word(OP_RELEASE, '0, 6'd63);
        // fills into the first empty slots, extreme keys
        send_word(OP_LOOKUP, '0, 6'd63);
        send_word(OP_LOOKUP, '1, 6'd0);
        // hits raise the counts
        send_word(OP_LOOKUP, '0, 6'd21);
        send_word(OP_LOOKUP, '1, 6'd42);
        // count down to zero, then one release too many
        send_word(OP_RELEASE, 64'h5555_5555_5555_5555, 6'd1);
        send_word(OP_RELEASE, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0);
        send_word(OP_RELEASE, '1, 6'd0);
        send_word(OP_RELEASE, '0, 6'd0);
        // an unreferenced entry is still a hit, not a victim, while slots are empty
        send_word(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0);
        send_word(OP_LOOKUP, 64'h5555_5555_5555_5555, 6'd63);
        send_word(OP_LOOKUP, 64'h8000_0000_0000_0001, 6'h2A);
        send_word(OP_RELEASE, 64'h7FFF_FFFF_FFFF_FFFE, 6'd2);
        send_word(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 6'h15);
        send_word(OP_RELEASE, '1, 6'd63);
        send_word(OP_RELEASE, '0, 6'd40);

        // back-to-back hits: slot 0 sits at zero and climbs one per word
        drain_results();
        steady = 1'b1;
        repeat (STEADY_RUN)
            send_word(OP_LOOKUP, '0, SLOT_W'($urandom));
        send_word(OP_RELEASE, any_key(), 6'd0);
        send_word(OP_LOOKUP, '0, 6'd0);
        steady = 1'b0;
        // sender waits for every result before the random part
        drain_results();

        // random part: fill phases pin the table until it reports full,
        // drain phases unpin entries so later misses evict them
        for (int ph = 0; ph < PHASES; ph++)
        begin
            repeat (PHASE_WORDS)
                send_random_word(ph % 2 == 0);
            if (ph % 3 == 2)
                drain_results();
        end

        drain_results();
        // a full scan plus margin, to catch a stray result
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("covered %0d lookups: %0d hits (%0d at the count ceiling),",
                 chk.n_hits + chk.n_fills + chk.n_full, chk.n_hits,
                 chk.n_ceiling_hits);
        $display("%0d fills, %0d evictions, %0d table full",
                 chk.n_fills, chk.n_evictions, chk.n_full);
        $display("and %0d releases (%0d rejected); %0d results checked",
                 chk.n_releases, chk.n_bad_releases, chk.words_checked);
        if (chk_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
